// ===== hw/rtl/smx_pkg.sv =====
// Shared types and constants of the stack-machine executor.
// Operation codes, event codes, controller states and the command/status
// structs that join the controller and the datapath. No dependencies.
package smx_pkg;

	localparam int KIND_W    = 4;
	localparam int NUM_W     = 32;
	localparam int VIDX_W    = 5;
	localparam int EVT_W     = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;
	localparam int BYTE_W    = 8;
	localparam int MOD_CNT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		OP_PUSH   = 4'd0,
		OP_ADD    = 4'd1,
		OP_SUB    = 4'd2,
		OP_MUL    = 4'd3,
		OP_SETVAR = 4'd4,
		OP_GETVAR = 4'd5,
		OP_POKE   = 4'd6,
		OP_PEEK   = 4'd7,
		OP_PRINT  = 4'd8,
		OP_CLEAR  = 4'd9,
		OP_PLANE  = 4'd10,
		OP_RSTK   = 4'd11
	} op_kind_t;

	typedef enum logic [EVT_W-1:0] {
		EVT_PRINT = 2'd0,
		EVT_CLEAR = 2'd1,
		EVT_PLANE = 2'd2
	} evt_t;

	typedef enum logic [1:0] {
		SRC_ALU,
		SRC_NUM,
		SRC_VAR,
		SRC_MEM
	} push_src_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP1,
		ST_POP2,
		ST_EXEC,
		ST_SETV,
		ST_MODS,
		ST_MODW,
		ST_PEEKW,
		ST_EMIT,
		ST_RSTK
	} state_t;

	typedef struct packed {
		logic      load;
		logic      pop;
		logic      take_b;
		logic      push;
		push_src_t push_src;
		alu_op_t   alu_op;
		logic      var_wr;
		logic      mod_start;
		logic      mem_wr;
		logic      mem_rd;
		logic      out_load;
		evt_t      out_evt;
		logic      clr_wr;
		logic      stk_rst;
	} smx_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic out_full;
	} smx_sts_t;

endpackage

// ===== hw/rtl/smx_ctrl.sv =====
// Controller state machine of the stack-machine executor.
// Sequences each operation into datapath commands; uses smx_pkg.
module smx_ctrl
	import smx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic [KIND_W-1:0]   kind,
	output logic                s_tready,
	input  smx_sts_t            sts,
	output smx_cmd_t            cmd
);

	state_t            state_q, state_d;
	logic [KIND_W-1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.push_src = SRC_ALU;
		cmd.alu_op   = ALU_ADD;
		cmd.out_evt  = EVT_PRINT;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					case (kind) inside
						OP_PUSH, OP_GETVAR: state_d = ST_EXEC;
						OP_ADD, OP_SUB, OP_MUL, OP_POKE, OP_SETVAR, OP_PEEK, OP_PRINT:
							state_d = ST_POP1;
						OP_CLEAR, OP_PLANE: state_d = ST_EMIT;
						OP_RSTK: state_d = ST_RSTK;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_POP1: begin
				cmd.pop = 1'b1;
				case (kind_q)
					OP_SETVAR: state_d = ST_SETV;
					OP_PEEK:   state_d = ST_MODS;
					OP_PRINT:  state_d = ST_EMIT;
					default:   state_d = ST_POP2;
				endcase
			end
			ST_POP2: begin
				cmd.take_b = 1'b1;
				cmd.pop    = 1'b1;
				state_d    = (kind_q == OP_POKE) ? ST_MODS : ST_EXEC;
			end
			ST_EXEC: begin
				cmd.push = 1'b1;
				case (kind_q)
					OP_PUSH:   cmd.push_src = SRC_NUM;
					OP_GETVAR: cmd.push_src = SRC_VAR;
					default:   cmd.push_src = SRC_ALU;
				endcase
				case (kind_q)
					OP_SUB:  cmd.alu_op = ALU_SUB;
					OP_MUL:  cmd.alu_op = ALU_MUL;
					default: cmd.alu_op = ALU_ADD;
				endcase
				state_d = ST_IDLE;
			end
			ST_SETV: begin
				cmd.var_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_MODS: begin
				cmd.mod_start = 1'b1;
				state_d       = ST_MODW;
			end
			ST_MODW: begin
				if (sts.mod_done) begin
					if (kind_q == OP_POKE) begin
						cmd.mem_wr = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.mem_rd = 1'b1;
						state_d    = ST_PEEKW;
					end
				end
			end
			ST_PEEKW: begin
				cmd.push     = 1'b1;
				cmd.push_src = SRC_MEM;
				state_d      = ST_IDLE;
			end
			ST_EMIT: begin
				case (kind_q)
					OP_CLEAR: cmd.out_evt = EVT_CLEAR;
					OP_PLANE: cmd.out_evt = EVT_PLANE;
					default:  cmd.out_evt = EVT_PRINT;
				endcase
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RSTK: begin
				cmd.stk_rst = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/smx_dp.sv =====
// Datapath of the stack-machine executor: stack RAM, depth counter,
// variables, byte memory with its address reduction, ALU and output register.
// Uses smx_pkg; driven by smx_ctrl commands.
module smx_dp
	import smx_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int VAR_COUNT   = 26,
	parameter int MEM_BYTES   = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smx_cmd_t             cmd,
	output smx_sts_t             sts,
	input  logic [NUM_W-1:0]     number,
	input  logic [VIDX_W-1:0]    var_index,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [EVT_W-1:0]     event_res,
	output logic [NUM_W-1:0]     printed
);

	localparam int  DW       = $clog2(STACK_DEPTH + 1);
	localparam int  SAW      = $clog2(STACK_DEPTH);
	localparam int  VIW      = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
	localparam int  AW       = $clog2(MEM_BYTES);
	localparam bit  MEM_POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;

	logic [NUM_W-1:0]  number_q;
	logic [VIDX_W-1:0] vidx_q;
	logic [DW-1:0]     depth_q;
	logic              pop_ok_q;
	logic [NUM_W-1:0]  stk_rd_q;
	logic [NUM_W-1:0]  pop_val;
	logic [NUM_W-1:0]  b_q;
	logic [NUM_W-1:0]  stack_mem [STACK_DEPTH];
	logic [NUM_W-1:0]  var_q [VAR_COUNT];
	logic              var_ok;
	logic [NUM_W-1:0]  var_val;
	logic [BYTE_W-1:0] byte_mem [MEM_BYTES];
	logic [BYTE_W-1:0] mem_rd_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     mem_addr;
	logic              mod_done;
	logic [NUM_W-1:0]  alu_res;
	logic [NUM_W-1:0]  push_val;
	logic              stk_full;
	logic              stk_empty;
	logic [DW-1:0]     rd_depth;
	logic              out_valid_q;
	logic [EVT_W-1:0]  out_evt_q;
	logic [NUM_W-1:0]  out_data_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			number_q <= number;
			vidx_q   <= var_index;
		end
	end

	// A pop from the empty stack yields zero through pop_ok_q.
	assign pop_val   = pop_ok_q ? stk_rd_q : '0;
	assign stk_full  = depth_q >= DW'(STACK_DEPTH);
	assign stk_empty = depth_q == '0;
	assign rd_depth  = depth_q - DW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			pop_ok_q <= 1'b0;
		end else begin
			if (cmd.stk_rst) begin
				depth_q <= '0;
			end else if (cmd.pop) begin
				pop_ok_q <= !stk_empty;
				if (!stk_empty) begin
					depth_q <= rd_depth;
				end
			end else if (cmd.push && !stk_full) begin
				depth_q <= depth_q + DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !stk_full) begin
			stack_mem[depth_q[SAW-1:0]] <= push_val;
		end
		if (cmd.pop && !stk_empty) begin
			stk_rd_q <= stack_mem[rd_depth[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_b) begin
			b_q <= pop_val;
		end
	end

	always_comb begin
		case (cmd.alu_op)
			ALU_SUB: alu_res = pop_val - b_q;
			ALU_MUL: alu_res = pop_val * b_q;
			default: alu_res = pop_val + b_q;
		endcase
	end

	assign var_ok  = vidx_q < VIDX_W'(VAR_COUNT);
	assign var_val = var_ok ? var_q[vidx_q[VIW-1:0]] : '0;

	always_comb begin
		case (cmd.push_src)
			SRC_NUM: push_val = number_q;
			SRC_VAR: push_val = var_val;
			SRC_MEM: push_val = {{(NUM_W - BYTE_W){1'b0}}, mem_rd_q};
			default: push_val = alu_res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VAR_COUNT; i++) begin
				var_q[i] <= '0;
			end
		end else if (cmd.var_wr && var_ok) begin
			var_q[vidx_q[VIW-1:0]] <= pop_val;
		end
	end

	// Address reduction modulo MEM_BYTES: a mask for a power of two,
	// otherwise a quotient estimate by the scaled reciprocal, which is at
	// most one low, so one compare and subtract finishes the remainder.
	generate
		if (MEM_POW2) begin : g_mask
			logic [AW-1:0] addr_q;
			always_ff @(posedge clk) begin
				if (cmd.mod_start) begin
					addr_q <= pop_val[AW-1:0];
				end
			end
			assign mem_addr = addr_q;
			assign mod_done = 1'b1;
		end else begin : g_recip
			localparam logic [NUM_W-1:0] RECIP = NUM_W'((64'd1 << NUM_W) / MEM_BYTES);
			logic [NUM_W-1:0]     val_q;
			logic [NUM_W-1:0]     quot_q;
			logic [NUM_W-1:0]     qn_q;
			logic [NUM_W-1:0]     diff;
			logic [2*NUM_W-1:0]   prod;
			logic [AW-1:0]        rem_q;
			logic [MOD_CNT_W-1:0] cnt_q;
			assign prod = (2*NUM_W)'(val_q) * (2*NUM_W)'(RECIP);
			assign diff = val_q - qn_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
				end else if (cmd.mod_start) begin
					cnt_q <= MOD_CNT_W'(3);
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - MOD_CNT_W'(1);
				end
			end
			always_ff @(posedge clk) begin
				if (cmd.mod_start) begin
					val_q <= pop_val;
				end
				if (cnt_q == MOD_CNT_W'(3)) begin
					quot_q <= prod[2*NUM_W-1:NUM_W];
				end
				if (cnt_q == MOD_CNT_W'(2)) begin
					qn_q <= quot_q * NUM_W'(MEM_BYTES);
				end
				if (cnt_q == MOD_CNT_W'(1)) begin
					if (diff >= NUM_W'(MEM_BYTES)) begin
						rem_q <= AW'(diff - NUM_W'(MEM_BYTES));
					end else begin
						rem_q <= AW'(diff);
					end
				end
			end
			assign mem_addr = rem_q;
			assign mod_done = cnt_q == '0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			byte_mem[clr_q] <= '0;
		end else if (cmd.mem_wr) begin
			byte_mem[mem_addr] <= b_q[BYTE_W-1:0];
		end
		if (cmd.mem_rd) begin
			mem_rd_q <= byte_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_evt_q  <= cmd.out_evt;
			out_data_q <= (cmd.out_evt == EVT_PRINT) ? pop_val : '0;
		end
	end

	assign m_tvalid  = out_valid_q;
	assign event_res = out_evt_q;
	assign printed   = out_data_q;

	assign sts.clr_last = clr_q == AW'(MEM_BYTES - 1);
	assign sts.mod_done = mod_done;
	assign sts.out_full = out_valid_q && !m_tready;

endmodule

// ===== hw/rtl/stack_machine_executor_core.sv =====
// Top level of the stack-machine executor: stream ports, controller and
// datapath. Depends on smx_pkg, smx_ctrl and smx_dp.
//
// Executes one decoded stack-machine operation per input beat and emits one
// output beat for print, clear screen and draw plane. Items are handled one
// at a time; the stack is a single-port RAM with registered read, so each
// popped operand takes a state of its own. Add, sub and mul pop two operands
// and push the result; setvar, print and peek pop one, poke pops two. When
// MEM_BYTES is not a power of two the byte address is reduced by a reciprocal
// multiplication and one correcting subtraction, which lengthens poke and peek.
// Print, clear and plane wait in place only while an earlier output beat is
// still held. After reset the byte memory is cleared by a pass over all
// MEM_BYTES addresses, during which no input beat is accepted. Pushes onto a
// full stack are dropped, pops from an empty stack yield zero and arithmetic
// wraps modulo 2^32.
module stack_machine_executor_core
	import smx_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int VAR_COUNT   = 26,
	parameter int MEM_BYTES   = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] number, [36:32] var_index, rest zero
	input  logic [KIND_W-1:0]     s_tuser,   // [3:0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] printed
	output logic [EVT_W-1:0]      m_tuser    // [1:0] event_res
);

	smx_cmd_t cmd;
	smx_sts_t sts;

	smx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smx_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.VAR_COUNT   (VAR_COUNT),
		.MEM_BYTES   (MEM_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.number    (s_tdata[NUM_W-1:0]),
		.var_index (s_tdata[NUM_W+VIDX_W-1:NUM_W]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.event_res (m_tuser),
		.printed   (m_tdata)
	);

`ifndef ASSERT_OFF
	// The stack RAM has one port: a push never shares a cycle with a pop.
	a_stack_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("stack push and pop in the same cycle");

	// A new event is loaded only when the output register is free or draining.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid && !m_tready))
		else $error("output beat overwritten while held");

	// No input beat is taken while the byte memory is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !s_tready)
		else $error("input ready during clearing pass");

	// An operand is never popped while an input beat can be accepted.
	a_pop_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !s_tready)
		else $error("input ready while popping an operand");
`endif

endmodule
